FILE: design/bpp_pkg.sv
// Shared types and constants for the calculator bank paging ports block.
`default_nettype none

package bpp_pkg;

  localparam int unsigned PageW    = 6;
  localparam int unsigned RamPageW = 3;
  localparam int unsigned DataW    = 8;

  typedef enum logic [1:0] {
    PORT_MODE   = 2'd0,
    PORT_RAM    = 2'd1,
    PORT_BANK_A = 2'd2,
    PORT_BANK_B = 2'd3
  } port_e;

  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } req_e;

  localparam int unsigned FlashBitLarge = 7;
  localparam int unsigned FlashBitSmall = 6;
  localparam logic [PageW-1:0] PageMaskLarge = 6'h3F;
  localparam logic [PageW-1:0] PageMaskSmall = 6'h1F;

  typedef struct packed {
    logic [PageW-1:0]    page_a;
    logic                flash_a;
    logic [PageW-1:0]    page_b;
    logic                flash_b;
    logic [RamPageW-1:0] ram_page;
    logic                pair_map;
  } bpp_state_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic [PageW-1:0] bank1_page;
    logic             bank1_is_flash;
    logic [PageW-1:0] bank2_page;
    logic             bank2_is_flash;
    logic [PageW-1:0] bank3_page;
    logic             bank3_is_flash;
  } bpp_result_t;

  typedef struct packed {
    logic       write;
    port_e      port;
    logic [7:0] data;
  } bpp_req_t;

endpackage

`default_nettype wire

FILE: design/bpp_state.sv
// Paging state registers and their update on each accepted port access.
`default_nettype none

module bpp_state import bpp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       acc_i,
  input  wire logic       small_i,
  input  wire bpp_req_t   req_i,
  output      bpp_state_t state_q_o,
  output      bpp_state_t state_d_o
);

  bpp_state_t state_q, state_d;
  logic       flash_in;
  logic [PageW-1:0] page_in;

  always_comb begin
    flash_in = small_i ? req_i.data[FlashBitSmall] : req_i.data[FlashBitLarge];
    page_in  = req_i.data[PageW-1:0] & (small_i ? PageMaskSmall : PageMaskLarge);
    state_d  = state_q;
    if (req_i.write) begin
      unique case (req_i.port)
        PORT_MODE: state_d.pair_map = req_i.data[0];
        PORT_RAM: begin
          if (!small_i) state_d.ram_page = req_i.data[RamPageW-1:0];
        end
        PORT_BANK_A: begin
          state_d.page_a  = page_in;
          state_d.flash_a = flash_in;
        end
        PORT_BANK_B: begin
          state_d.page_b  = page_in;
          state_d.flash_b = flash_in;
        end
        default: state_d = state_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{page_a: '0, flash_a: 1'b1, page_b: '0, flash_b: 1'b1,
                   ram_page: '0, pair_map: 1'b0};
    end else if (acc_i) begin
      state_q <= state_d;
    end
  end

  assign state_q_o = state_q;
  assign state_d_o = state_d;

endmodule

`default_nettype wire

FILE: design/bpp_result.sv
// Read data and bank mapping for one port access.
`default_nettype none

module bpp_result import bpp_pkg::*; (
  input  wire logic        small_i,
  input  wire bpp_req_t    req_i,
  input  wire bpp_state_t  cur_i,
  input  wire bpp_state_t  nxt_i,
  output      bpp_result_t res_o
);

  logic [DataW-1:0] flash_mask;

  always_comb begin
    flash_mask = small_i ? DataW'(1 << FlashBitSmall) : DataW'(1 << FlashBitLarge);
    res_o = '0;
    if (!req_i.write) begin
      unique case (req_i.port)
        PORT_MODE:   res_o.read_data = '0;
        PORT_RAM:    res_o.read_data = small_i ? '0 : DataW'(cur_i.ram_page);
        PORT_BANK_A: res_o.read_data = DataW'(cur_i.page_a)
                                     | (cur_i.flash_a ? flash_mask : '0);
        PORT_BANK_B: res_o.read_data = DataW'(cur_i.page_b)
                                     | (cur_i.flash_b ? flash_mask : '0);
        default:     res_o.read_data = '0;
      endcase
    end
    if (!nxt_i.pair_map) begin
      res_o.bank1_page     = nxt_i.page_a;
      res_o.bank1_is_flash = nxt_i.flash_a;
      res_o.bank2_page     = nxt_i.page_b;
      res_o.bank2_is_flash = nxt_i.flash_b;
      res_o.bank3_page     = small_i ? '0 : PageW'(nxt_i.ram_page);
      res_o.bank3_is_flash = 1'b0;
    end else begin
      res_o.bank1_page     = {nxt_i.page_a[PageW-1:1], 1'b0};
      res_o.bank1_is_flash = nxt_i.flash_a;
      res_o.bank2_page     = small_i ? nxt_i.page_a : {nxt_i.page_a[PageW-1:1], 1'b1};
      res_o.bank2_is_flash = nxt_i.flash_a;
      res_o.bank3_page     = nxt_i.page_b;
      res_o.bank3_is_flash = nxt_i.flash_b;
    end
  end

endmodule

`default_nettype wire

FILE: design/calculator_bank_paging_ports.sv
// Top level of the calculator bank paging ports block.
// The result of an accepted item is loaded into the output register.
// One item per cycle unless out_ready_i stalls; output reg reloads as taken.
// Reset: asynchronous, active low; both banks flash page 0, RAM page 0, mode 0,
// large variant selected, no result pending.
`default_nettype none

module calculator_bank_paging_ports import bpp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_data_i,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic             req_type_i,
  input  wire logic [1:0]       port_select_i,
  input  wire logic [DataW-1:0] write_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic [DataW-1:0] read_data_o,
  output      logic [PageW-1:0] bank1_page_o,
  output      logic             bank1_is_flash_o,
  output      logic [PageW-1:0] bank2_page_o,
  output      logic             bank2_is_flash_o,
  output      logic [PageW-1:0] bank3_page_o,
  output      logic             bank3_is_flash_o
);

  logic        small_q;
  logic        out_valid_q;
  logic        in_acc;
  bpp_req_t    req;
  bpp_state_t  cur_state, nxt_state;
  bpp_result_t res_d, res_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign req        = '{write: req_type_i, port: port_e'(port_select_i),
                        data: write_data_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      small_q <= 1'b0;
    end else if (cfg_we_i) begin
      small_q <= cfg_data_i;
    end
  end

  bpp_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (in_acc),
    .small_i   (small_q),
    .req_i     (req),
    .state_q_o (cur_state),
    .state_d_o (nxt_state)
  );

  bpp_result u_result (
    .small_i (small_q),
    .req_i   (req),
    .cur_i   (cur_state),
    .nxt_i   (nxt_state),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = res_q.read_data;
  assign bank1_page_o     = res_q.bank1_page;
  assign bank1_is_flash_o = res_q.bank1_is_flash;
  assign bank2_page_o     = res_q.bank2_page;
  assign bank2_is_flash_o = res_q.bank2_is_flash;
  assign bank3_page_o     = res_q.bank3_page;
  assign bank3_is_flash_o = res_q.bank3_is_flash;

  a_acc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted item produced no result");

  a_mode_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req_type_i == REQ_WRITE && port_select_i == PORT_MODE)
    |=> cur_state.pair_map == $past(write_data_i[0]))
    else $error("mode write not stored");

  a_small_ram_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && small_q && port_select_i == PORT_RAM) |=> $stable(cur_state.ram_page))
    else $error("RAM page changed in small variant");

  a_write_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req_type_i == REQ_WRITE) |=> read_data_o == '0)
    else $error("write returned nonzero read data");

endmodule

`default_nettype wire
